// ===== src/cav_pkg.sv =====
// Shared constants, tables and codes of the comb and allpass reverberator.
package cav_pkg;

	// Defaults of the top-level parameters.
	localparam int DELAY_DEPTH_DEF    = 8192;
	localparam int NUM_COMBS_DEF      = 4;
	localparam int NUM_ALLPASS_DEF    = 3;
	localparam int INTERNAL_WIDTH_DEF = 24;

	localparam int MAX_COMBS   = 4;
	localparam int MAX_ALLPASS = 3;
	localparam int NUM_ROWS    = 3;

	// Configuration port.
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SAMPLE_RATE = 2'd0,
		REG_STRENGTH    = 2'd1,
		REG_COMB_FB     = 2'd2,
		REG_COMB_GAIN   = 2'd3
	} cfg_reg_t;

	localparam logic [15:0] RATE_RESET      = 16'd16000;
	localparam logic [1:0]  STRENGTH_RESET  = 2'd1;
	localparam logic [14:0] COMB_FB_RESET   = 15'd22938;
	localparam logic [14:0] COMB_GAIN_RESET = 15'd24576;

	// Input scale 0.5/32767 in Q.36 applied with a 16-bit rounding shift.
	localparam logic [20:0] IN_SCALE = 21'd1048608;
	localparam int          IN_SHIFT = 16;
	// Wet mix gain 0.7 in Q0.15.
	localparam logic [14:0] MIX_GAIN = 15'd22938;

	// floor(x / 100000) as (x * LEN_RECIP) >> LEN_SHIFT, exact for x below 2^30.
	localparam logic [30:0] LEN_RECIP = 31'd1407374884;
	localparam int          LEN_SHIFT = 47;
	localparam int          LEN_PROD_W = 61;

	typedef logic [13:0] ms100_t;

	// Delay times in hundredths of a millisecond.
	localparam ms100_t COMB_MS100 [MAX_COMBS] = '{14'd1906, 14'd2156, 14'd2375, 14'd2562};
	localparam ms100_t AP_MS100 [NUM_ROWS][MAX_ALLPASS] = '{
		'{14'd8430, 14'd9680, 14'd7320},
		'{14'd4430, 14'd5680, 14'd3720},
		'{14'd8430, 14'd9680, 14'd7320}
	};
	// Allpass gains in Q0.15.
	localparam logic [14:0] AP_GAIN [NUM_ROWS][MAX_ALLPASS] = '{
		'{15'd27197, 15'd26542, 15'd27853},
		'{15'd30474, 15'd29819, 15'd31130},
		'{15'd30474, 15'd29819, 15'd31130}
	};

	// Output shaper: scaled tanh samples on a grid of 1/64.
	localparam int SIG_LAST      = 24;
	localparam int SIG_STEP_BITS = 14;
	localparam int SIG_IDX_W     = 5;
	localparam logic [18:0] SIG_LIMIT = 19'(SIG_LAST << SIG_STEP_BITS);
	localparam logic [24:0] SIG_ROUND = 25'(1 << (SIG_STEP_BITS - 1));
	localparam logic [15:0] SIG_TAB [SIG_LAST+1] = '{
		16'd0,     16'd1536,  16'd3070,  16'd4600,  16'd6126,  16'd7645,  16'd9155,
		16'd10656, 16'd12146, 16'd13622, 16'd15084, 16'd16531, 16'd17960, 16'd19372,
		16'd20763, 16'd22135, 16'd23485, 16'd24812, 16'd26116, 16'd27396, 16'd28651,
		16'd29880, 16'd31084, 16'd32261, 16'd33411
	};

	localparam logic [15:0] OUT_MAX = 16'h7fff;
	localparam logic [15:0] OUT_MIN = 16'h8000;

	// Most items the pipeline can hold at once (all sections present).
	localparam int MAX_INFLIGHT = 7 + 5 * MAX_ALLPASS + 4;

	// Strength three behaves as strong.
	function automatic logic [1:0] strength_row(input logic [1:0] s);
		logic [1:0] r;
		priority if (s == 2'd0) r = 2'd0;
		else if (s == 2'd1) r = 2'd1;
		else r = 2'd2;
		return r;
	endfunction

endpackage

// ===== src/comb_allpass_reverb.sv =====
// Top level of the comb and allpass reverberator with its delay memories.
//
// Schroeder reverberator on a 16-bit sample stream. Each sample is scaled into
// fixed point, fed to NUM_COMBS parallel feedback combs whose outputs are summed,
// passed through NUM_ALLPASS allpass sections in series, mixed with the dry
// signal and shaped by a sigmoid table to a saturated 16-bit result. Every delay
// line is its own DELAY_DEPTH-word memory with one write and one registered read
// per cycle, so one sample enters per clock in steady state. Both channels
// transfer on valid and ready; a stalled output holds the whole pipeline and
// drops in_ready. After reset the block zeroes its delay memories in a pass
// over all DELAY_DEPTH addresses with in_ready low; configuration writes are
// taken during that pass. A configuration write holds in_ready low while the
// delay lengths are recomputed through two multipliers. If any delay length
// comes out as exactly one sample, a sample can only enter when the first stage
// is empty, which halves the rate, because a line would otherwise read a word its
// predecessor has not yet written.
module comb_allpass_reverb
	import cav_pkg::*;
#(
	parameter int DELAY_DEPTH    = DELAY_DEPTH_DEF,
	parameter int NUM_COMBS      = NUM_COMBS_DEF,
	parameter int NUM_ALLPASS    = NUM_ALLPASS_DEF,
	parameter int INTERNAL_WIDTH = INTERNAL_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic signed [15:0]    sample_in,
	input  logic                  block_end,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [15:0]    sample_out,
	output logic                  block_end_out,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW   = $clog2(DELAY_DEPTH);
	localparam int W    = INTERNAL_WIDTH;
	localparam int XW   = W + 8;
	localparam int PW   = W + 16;
	localparam int NL   = NUM_COMBS + NUM_ALLPASS;
	localparam int AP0  = 7;
	localparam int MIX  = AP0 + 5 * NUM_ALLPASS;
	localparam int LAST = MIX + 4;
	localparam int WP_LAST = MIX - 3;
	localparam int DRY_PW  = 38;
	localparam logic [PW-1:0]     RND15  = PW'(1) << 14;
	localparam logic [DRY_PW-1:0] RND_IN = DRY_PW'(1) << (IN_SHIFT - 1);
	localparam logic [AW-1:0]     ADDR_LAST = AW'(DELAY_DEPTH - 1);

	// Saturate a wide value to the internal width.
	function automatic logic signed [W-1:0] sat_w(input logic signed [XW-1:0] v);
		logic signed [W-1:0] r;
		if ((&v[XW-1:W-1]) || ~(|v[XW-1:W-1])) begin
			r = v[W-1:0];
		end else if (v[XW-1]) begin
			r = {1'b1, {(W-1){1'b0}}};
		end else begin
			r = {1'b0, {(W-1){1'b1}}};
		end
		return r;
	endfunction

	// Round half up, then drop 15 fraction bits of a Q0.15 product.
	function automatic logic signed [W:0] rnd15(input logic signed [PW-1:0] p);
		logic [PW-1:0] t;
		t = p + RND15;
		return $signed(t[PW-1:15]);
	endfunction

	// Configuration registers and derived delay lengths.
	logic [15:0] rate_q;
	logic [1:0]  str_q;
	logic [14:0] fb_q;
	logic [14:0] og_q;
	logic [1:0]  cfg_hold_q;
	logic [1:0]  row;
	logic [29:0]   len_p_q [NL];
	logic [AW-1:0] len_q   [NL];
	logic          gap_need;

	// Clearing pass.
	logic          clr_busy_q;
	logic [AW-1:0] clr_addr_q;

	// Pipeline control and carried fields.
	logic          en;
	logic          in_xfer;
	logic [AW-1:0] wp_q;
	logic          vld_s [1:LAST];
	logic          blk_s [1:LAST];
	logic [AW-1:0] wp_s  [1:WP_LAST];
	logic signed [W-1:0] dry_s [3:MIX+1];
	logic signed [15:0]  smp_s1;
	logic signed [DRY_PW-1:0] prod_in_s2;
	logic [DRY_PW-1:0]        dry_rnd;

	// Comb lanes.
	logic signed [W-1:0]  crd     [NUM_COMBS];
	logic signed [PW-1:0] cm_s4   [NUM_COMBS];
	logic signed [W-1:0]  cfed    [NUM_COMBS];
	logic signed [W-1:0]  cfed_s5 [NUM_COMBS];
	logic signed [PW-1:0] co_s6   [NUM_COMBS];
	logic signed [XW-1:0] csum;
	logic signed [W-1:0]  acc_s7;

	// Allpass section outputs, each at the input stage of the next.
	logic signed [W-1:0] ap_out [NUM_ALLPASS];

	// Mix and shaper.
	logic signed [PW-1:0] mix_p_s1;
	logic signed [W-1:0]  mix_z;
	logic [W-1:0]         mix_mag;
	logic                 mix_ovf;
	logic                 sh_neg_s2, sh_ovf_s2;
	logic [SIG_IDX_W-1:0] sh_k_s2;
	logic [SIG_STEP_BITS-1:0] sh_f_s2;
	logic [15:0]          sh_t0, sh_t1, sh_diff;
	logic [24:0]          sh_prod;
	logic [16:0]          sh_v;
	logic                 sh_neg_s3, sh_ovf_s3;
	logic [16:0]          sh_v_s3;
	logic [15:0]          out_q;

	assign row = strength_row(str_q);

	// Configuration writes; the hold counter covers the registered length update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q     <= RATE_RESET;
			str_q      <= STRENGTH_RESET;
			fb_q       <= COMB_FB_RESET;
			og_q       <= COMB_GAIN_RESET;
			cfg_hold_q <= 2'd0;
		end else begin
			if (cfg_we) begin
				cfg_hold_q <= 2'd2;
				unique case (cfg_reg_t'(cfg_idx))
					REG_SAMPLE_RATE: rate_q <= cfg_data;
					REG_STRENGTH:    str_q  <= cfg_data[1:0];
					REG_COMB_FB:     fb_q   <= cfg_data[14:0];
					REG_COMB_GAIN:   og_q   <= cfg_data[14:0];
				endcase
			end else if (cfg_hold_q != 2'd0) begin
				cfg_hold_q <= cfg_hold_q - 2'd1;
			end
		end
	end

	// Delay length per line: floor(ms100 * rate / 100000), wrapped to the depth.
	for (genvar j = 0; j < NL; j++) begin : g_len
		ms100_t                ms;
		logic [LEN_PROD_W-1:0] len_full;
		if (j < NUM_COMBS) begin : g_c
			assign ms = COMB_MS100[j];
		end else begin : g_a
			assign ms = AP_MS100[row][j-NUM_COMBS];
		end
		assign len_full = LEN_PROD_W'(len_p_q[j]) * LEN_PROD_W'(LEN_RECIP);
		always_ff @(posedge clk) begin
			len_p_q[j] <= 30'(ms) * 30'(rate_q);
			len_q[j]   <= len_full[LEN_SHIFT +: AW];
		end
	end

	always_comb begin
		gap_need = 1'b0;
		for (int j = 0; j < NL; j++) begin
			gap_need = gap_need | (len_q[j] == AW'(1));
		end
	end

	// Zero all delay memories after reset, one address per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == ADDR_LAST) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// The whole pipeline advances together, so gaps between samples are kept.
	assign en       = ~vld_s[LAST] | out_ready;
	assign in_ready = en & ~clr_busy_q & (cfg_hold_q == 2'd0) & ~(gap_need & vld_s[1]);
	assign in_xfer  = in_valid & in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			for (int s = 1; s <= LAST; s++) begin
				vld_s[s] <= 1'b0;
			end
		end else begin
			if (in_xfer) begin
				wp_q <= wp_q + AW'(1);
			end
			if (en) begin
				vld_s[1] <= in_xfer;
				for (int s = 2; s <= LAST; s++) begin
					vld_s[s] <= vld_s[s-1];
				end
			end
		end
	end

	// Carried fields and the dry path.
	assign dry_rnd = prod_in_s2 + RND_IN;

	always_ff @(posedge clk) begin
		if (en) begin
			smp_s1   <= sample_in;
			blk_s[1] <= block_end;
			wp_s[1]  <= wp_q;
			for (int s = 2; s <= LAST; s++) begin
				blk_s[s] <= blk_s[s-1];
			end
			for (int s = 2; s <= WP_LAST; s++) begin
				wp_s[s] <= wp_s[s-1];
			end
			prod_in_s2 <= smp_s1 * $signed({1'b0, IN_SCALE});
			dry_s[3]   <= sat_w(XW'($signed(dry_rnd[DRY_PW-1:IN_SHIFT])));
			for (int s = 4; s <= MIX + 1; s++) begin
				dry_s[s] <= dry_s[s-1];
			end
		end
	end

	// Feedback combs: read at stage 2, write back at stage 4.
	for (genvar k = 0; k < NUM_COMBS; k++) begin : g_comb
		logic signed [W-1:0] mem [DELAY_DEPTH];
		logic [AW-1:0]       raddr, waddr;
		logic                we;
		logic signed [W-1:0] wdata;

		assign raddr   = wp_s[2] - len_q[k];
		assign cfed[k] = sat_w(XW'(dry_s[4]) + XW'(rnd15(cm_s4[k])));
		assign we      = clr_busy_q | (en & vld_s[4]);
		assign waddr   = clr_busy_q ? clr_addr_q : wp_s[4];
		assign wdata   = clr_busy_q ? '0 : cfed[k];

		always_ff @(posedge clk) begin
			if (we) begin
				mem[waddr] <= wdata;
			end
			if (en) begin
				crd[k] <= (we && (waddr == raddr)) ? wdata : mem[raddr];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				cm_s4[k]   <= crd[k] * $signed({1'b0, fb_q});
				cfed_s5[k] <= cfed[k];
				co_s6[k]   <= cfed_s5[k] * $signed({1'b0, og_q});
			end
		end
	end

	always_comb begin
		csum = '0;
		for (int k = 0; k < NUM_COMBS; k++) begin
			csum = csum + XW'(rnd15(co_s6[k]));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			acc_s7 <= sat_w(csum);
		end
	end

	// Allpass sections: five stages each, read at the first, write at the third.
	for (genvar k = 0; k < NUM_ALLPASS; k++) begin : g_ap
		localparam int B = AP0 + 5 * k;
		logic signed [W-1:0]  mem [DELAY_DEPTH];
		logic signed [W-1:0]  ap_in, rd, fed, wdata;
		logic [AW-1:0]        raddr, waddr;
		logic                 we;
		logic [14:0]          g;
		logic signed [W-1:0]  x_s1, x_s2, old_s2, old_s3, old_s4, fed_s3, y_s5;
		logic signed [PW-1:0] am_s2, ap_s4;

		if (k == 0) begin : g_first
			assign ap_in = acc_s7;
		end else begin : g_next
			assign ap_in = ap_out[k-1];
		end

		assign g     = AP_GAIN[row][k];
		assign raddr = wp_s[B] - len_q[NUM_COMBS+k];
		assign fed   = sat_w(XW'(x_s2) + XW'(rnd15(am_s2)));
		assign we    = clr_busy_q | (en & vld_s[B+2]);
		assign waddr = clr_busy_q ? clr_addr_q : wp_s[B+2];
		assign wdata = clr_busy_q ? '0 : fed;

		always_ff @(posedge clk) begin
			if (we) begin
				mem[waddr] <= wdata;
			end
			if (en) begin
				rd <= (we && (waddr == raddr)) ? wdata : mem[raddr];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s1   <= ap_in;
				x_s2   <= x_s1;
				old_s2 <= rd;
				am_s2  <= rd * $signed({1'b0, g});
				fed_s3 <= fed;
				old_s3 <= old_s2;
				ap_s4  <= fed_s3 * $signed({1'b0, g});
				old_s4 <= old_s3;
				y_s5   <= sat_w(XW'(old_s4) - XW'(rnd15(ap_s4)));
			end
		end

		assign ap_out[k] = y_s5;
	end

	// Wet and dry mix, then the sigmoid shaper on |z| with odd symmetry.
	assign mix_z   = sat_w(XW'(rnd15(mix_p_s1)) + XW'(dry_s[MIX+1]));
	assign mix_mag = mix_z[W-1] ? W'(-mix_z) : W'(mix_z);
	assign mix_ovf = mix_mag >= W'(SIG_LIMIT);

	assign sh_t0   = SIG_TAB[sh_k_s2];
	assign sh_t1   = SIG_TAB[sh_k_s2 + SIG_IDX_W'(1)];
	assign sh_diff = sh_t1 - sh_t0;
	assign sh_prod = 25'(sh_diff[10:0]) * 25'(sh_f_s2) + SIG_ROUND;
	assign sh_v    = 17'(sh_t0) + 17'(sh_prod[24:SIG_STEP_BITS]);

	always_ff @(posedge clk) begin
		if (en) begin
			mix_p_s1  <= ap_out[NUM_ALLPASS-1] * $signed({1'b0, MIX_GAIN});
			sh_neg_s2 <= mix_z[W-1];
			sh_ovf_s2 <= mix_ovf;
			sh_k_s2   <= mix_ovf ? '0 : mix_mag[SIG_STEP_BITS +: SIG_IDX_W];
			sh_f_s2   <= mix_mag[SIG_STEP_BITS-1:0];
			sh_neg_s3 <= sh_neg_s2;
			sh_ovf_s3 <= sh_ovf_s2;
			sh_v_s3   <= sh_v;
			// Values past the table or the int16 range clamp to the rails.
			if (sh_ovf_s3 || sh_v_s3[16] || sh_v_s3[15]) begin
				out_q <= sh_neg_s3 ? OUT_MIN : OUT_MAX;
			end else begin
				out_q <= sh_neg_s3 ? 16'(~sh_v_s3[15:0] + 16'd1) : sh_v_s3[15:0];
			end
		end
	end

	assign out_valid     = vld_s[LAST];
	assign sample_out    = $signed(out_q);
	assign block_end_out = blk_s[LAST];

endmodule

// ===== src/cav_checker.sv =====
// Port-level checks of the reverberator, bound to its top level.
module cav_checker
	import cav_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [15:0] sample_out,
	input logic               block_end_out,
	input logic               cfg_we
);

	logic [5:0] inflight_q;

	// Samples taken in but not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + 6'(in_valid & in_ready) - 6'(out_valid & out_ready);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample_out) && $stable(block_end_out))
		else $error("output changed while stalled");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |-> inflight_q != 6'd0)
		else $error("result delivered with no sample outstanding");

	a_inflight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 6'(MAX_INFLIGHT))
		else $error("more samples outstanding than pipeline stages");

	a_cfg_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !in_ready)
		else $error("sample taken right after a configuration write");

endmodule

bind comb_allpass_reverb cav_checker u_cav_checker (.*);
